FILE: sv/arp_cache_with_request_retry_defines.svh
// Assertion macros shared by the ARP cache block.
// Depends on nothing; included by the top level only.
`ifndef ARP_CACHE_WITH_REQUEST_RETRY_DEFINES_SVH
`define ARP_CACHE_WITH_REQUEST_RETRY_DEFINES_SVH

// Checks that an implication holds on every clock edge outside reset.
`define ARPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication, including the cycles spent in reset.
`define ARPC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/arpc_pkg.sv
// Shared types and constants for the ARP cache with request retry.
// Used by every module of the block; depends on nothing.
package arpc_pkg;

  localparam int CacheEntriesDefault   = 16;
  localparam int RequestEntriesDefault = 16;
  localparam logic [15:0] TimeoutReset  = 16'd15;
  localparam logic [2:0]  MaxTriesReset = 3'd5;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_QUEUE  = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RES_LOOKUP = 3'd0,
    RES_INSERT = 3'd1,
    RES_QUEUE  = 3'd2,
    RES_SEND   = 3'd3,
    RES_GIVEUP = 3'd4,
    RES_DONE   = 3'd5
  } res_kind_t;

  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_MAXTRIES = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic        hit;
    logic        pending_found;
    logic [47:0] out_mac;
    logic [31:0] out_ip;
    logic [2:0]  tries_done;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ_SCAN,
    ST_CACHE_SCAN,
    ST_EXPIRE,
    ST_REQ_SWEEP,
    ST_EMIT
  } eng_state_t;

  // Handshake between the front queue and the engine.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } cmd_t;

endpackage

FILE: sv/arpc_front.sv
// Front part: accepts items and holds them in a two-entry queue.
// Depends on arpc_pkg.
module arpc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  arpc_pkg::in_item_t in_item,
  output arpc_pkg::cmd_t     cmd,
  input  logic               take
);

  arpc_pkg::in_item_t slots [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = take && (count != 2'd0);
  assign cmd.valid = (count != 2'd0);
  assign cmd.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: sv/arpc_engine.sv
// Back part: owns the cache and request tables and walks them one slot a cycle,
// holding while the result queue is full. Depends on arpc_pkg; results go to the output queue.
module arpc_engine #(
  parameter int CACHE_ENTRIES   = arpc_pkg::CacheEntriesDefault,
  parameter int REQUEST_ENTRIES = arpc_pkg::RequestEntriesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  arpc_pkg::cmd_t      cmd,
  output logic                take,
  input  logic [15:0]         timeout,
  input  logic [2:0]          max_tries,
  output logic                res_valid,
  output arpc_pkg::out_item_t res_item,
  input  logic                res_room
);

  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int RW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;

  logic [CACHE_ENTRIES-1:0]   e_valid;
  logic [31:0]                e_ip    [CACHE_ENTRIES];
  logic [47:0]                e_mac   [CACHE_ENTRIES];
  logic [31:0]                e_added [CACHE_ENTRIES];
  logic [REQUEST_ENTRIES-1:0] r_valid;
  logic [31:0]                r_ip    [REQUEST_ENTRIES];
  logic [2:0]                 r_tries [REQUEST_ENTRIES];

  logic [31:0] now_seconds;

  arpc_pkg::eng_state_t state, state_next;
  arpc_pkg::in_item_t   cur;
  logic [CW-1:0] cidx;
  logic [RW-1:0] ridx;

  // Scan results.
  logic          pend;
  logic [RW-1:0] pend_idx;
  logic          rfree;
  logic [RW-1:0] rfree_idx;
  logic          chit;
  logic [47:0]   cmac;
  logic          cfree;
  logic [CW-1:0] cfree_idx;

  logic cidx_end;
  logic ridx_end;
  logic r_match;
  logic c_match;
  logic aged;
  logic give_up;
  logic [2:0] tries_inc;
  logic [31:0] age;

  assign cidx_end  = ({{(32-CW){1'b0}}, cidx} == 32'(CACHE_ENTRIES - 1));
  assign ridx_end  = ({{(32-RW){1'b0}}, ridx} == 32'(REQUEST_ENTRIES - 1));
  assign r_match   = r_valid[ridx] && (r_ip[ridx] == cur.ip_addr);
  assign c_match   = e_valid[cidx] && (e_ip[cidx] == cur.ip_addr);
  assign age       = now_seconds - e_added[cidx];
  assign aged      = e_valid[cidx] && (age > {16'd0, timeout});
  assign give_up   = r_tries[ridx] >= max_tries;
  assign tries_inc = r_tries[ridx] + 3'd1;

  always_comb begin
    state_next = state;
    unique case (state)
      arpc_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          unique case (arpc_pkg::kind_t'(cmd.item.kind))
            arpc_pkg::KIND_LOOKUP: state_next = arpc_pkg::ST_CACHE_SCAN;
            arpc_pkg::KIND_TICK:   state_next = arpc_pkg::ST_EXPIRE;
            default:               state_next = arpc_pkg::ST_REQ_SCAN;
          endcase
        end
      end
      arpc_pkg::ST_REQ_SCAN: begin
        if (ridx_end) begin
          state_next = (cur.kind == arpc_pkg::KIND_INSERT) ?
                       arpc_pkg::ST_CACHE_SCAN : arpc_pkg::ST_EMIT;
        end
      end
      arpc_pkg::ST_CACHE_SCAN: if (cidx_end) state_next = arpc_pkg::ST_EMIT;
      arpc_pkg::ST_EXPIRE:     if (cidx_end) state_next = arpc_pkg::ST_REQ_SWEEP;
      arpc_pkg::ST_REQ_SWEEP: begin
        if (ridx_end && (!r_valid[ridx] || res_room)) state_next = arpc_pkg::ST_EMIT;
      end
      arpc_pkg::ST_EMIT:       if (res_room) state_next = arpc_pkg::ST_IDLE;
      default:                 state_next = arpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take      = (state == arpc_pkg::ST_IDLE) && cmd.valid;
    res_valid = 1'b0;
    res_item  = '0;
    unique case (state)
      arpc_pkg::ST_REQ_SWEEP: begin
        res_valid           = r_valid[ridx];
        res_item.out_ip     = r_ip[ridx];
        res_item.result_kind = give_up ? arpc_pkg::RES_GIVEUP : arpc_pkg::RES_SEND;
        res_item.tries_done = give_up ? r_tries[ridx] : tries_inc;
      end
      arpc_pkg::ST_EMIT: begin
        res_valid     = 1'b1;
        res_item.last = 1'b1;
        unique case (arpc_pkg::kind_t'(cur.kind))
          arpc_pkg::KIND_LOOKUP: begin
            res_item.result_kind = arpc_pkg::RES_LOOKUP;
            res_item.hit         = chit;
            res_item.out_mac     = chit ? cmac : 48'd0;
          end
          arpc_pkg::KIND_INSERT: begin
            res_item.result_kind   = arpc_pkg::RES_INSERT;
            res_item.hit           = cfree;
            res_item.pending_found = pend;
            res_item.out_ip        = cur.ip_addr;
            res_item.tries_done    = pend ? r_tries[pend_idx] : 3'd0;
          end
          arpc_pkg::KIND_QUEUE: begin
            res_item.result_kind   = arpc_pkg::RES_QUEUE;
            res_item.hit           = pend || rfree;
            res_item.pending_found = pend;
            res_item.out_ip        = cur.ip_addr;
            res_item.tries_done    = pend ? r_tries[pend_idx] : 3'd0;
          end
          default: res_item.result_kind = arpc_pkg::RES_DONE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) cur <= cmd.item;
    unique case (state)
      arpc_pkg::ST_REQ_SWEEP: begin
        if (r_valid[ridx] && res_room && !give_up) r_tries[ridx] <= tries_inc;
      end
      arpc_pkg::ST_EMIT: begin
        if (res_room && cur.kind == arpc_pkg::KIND_INSERT && cfree) begin
          e_ip[cfree_idx]    <= cur.ip_addr;
          e_mac[cfree_idx]   <= cur.mac_addr;
          e_added[cfree_idx] <= now_seconds;
        end
        if (res_room && cur.kind == arpc_pkg::KIND_QUEUE && !pend && rfree) begin
          r_ip[rfree_idx]    <= cur.ip_addr;
          r_tries[rfree_idx] <= 3'd0;
        end
      end
      default: ;
    endcase

    if (rst) begin
      state       <= arpc_pkg::ST_IDLE;
      e_valid     <= '0;
      r_valid     <= '0;
      now_seconds <= '0;
      cidx        <= '0;
      ridx        <= '0;
      pend        <= 1'b0;
      pend_idx    <= '0;
      rfree       <= 1'b0;
      rfree_idx   <= '0;
      chit        <= 1'b0;
      cmac        <= '0;
      cfree       <= 1'b0;
      cfree_idx   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        arpc_pkg::ST_IDLE: begin
          cidx  <= '0;
          ridx  <= '0;
          pend  <= 1'b0;
          rfree <= 1'b0;
          chit  <= 1'b0;
          cfree <= 1'b0;
          if (take && cmd.item.kind == arpc_pkg::KIND_TICK) now_seconds <= now_seconds + 32'd1;
        end
        arpc_pkg::ST_REQ_SCAN: begin
          // The first valid match is the one the table knows.
          if (r_match && !pend) begin
            pend     <= 1'b1;
            pend_idx <= ridx;
          end
          if (!r_valid[ridx] && !rfree) begin
            rfree     <= 1'b1;
            rfree_idx <= ridx;
          end
          ridx <= ridx_end ? '0 : ridx + RW'(1);
        end
        arpc_pkg::ST_CACHE_SCAN: begin
          if (c_match) begin
            chit <= 1'b1;
            cmac <= e_mac[cidx];
          end
          if (!e_valid[cidx] && !cfree) begin
            cfree     <= 1'b1;
            cfree_idx <= cidx;
          end
          cidx <= cidx_end ? '0 : cidx + CW'(1);
        end
        arpc_pkg::ST_EXPIRE: begin
          if (aged) e_valid[cidx] <= 1'b0;
          cidx <= cidx_end ? '0 : cidx + CW'(1);
        end
        arpc_pkg::ST_REQ_SWEEP: begin
          if (!r_valid[ridx] || res_room) begin
            if (r_valid[ridx] && give_up) r_valid[ridx] <= 1'b0;
            ridx <= ridx_end ? '0 : ridx + RW'(1);
          end
        end
        arpc_pkg::ST_EMIT: begin
          if (res_room) begin
            if (cur.kind == arpc_pkg::KIND_INSERT) begin
              if (pend) r_valid[pend_idx] <= 1'b0;
              if (cfree) e_valid[cfree_idx] <= 1'b1;
            end
            if (cur.kind == arpc_pkg::KIND_QUEUE && !pend && rfree) begin
              r_valid[rfree_idx] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/arpc_outq.sv
// Result queue: two entries that part the engine from the consumer.
// Depends on arpc_pkg.
module arpc_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  arpc_pkg::out_item_t wr_item,
  output logic                room,
  output logic                empty,
  input  logic                pop,
  output arpc_pkg::out_item_t rd_item
);

  arpc_pkg::out_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign room    = (count != 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr && room;
  assign do_rd   = pop && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_item;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

FILE: sv/arp_cache_with_request_retry.sv
// ARP cache with entry aging and request retry. Items enter through a two-entry
// queue; one engine walks the tables a slot per cycle, holding while the result queue
// is full. A lookup scans the cache table, an insert the request table and then the
// cache table, a queue item the request table, and a tick ages the cache table and
// then sweeps the request table. Results leave through a two-entry queue.
// Depends on arpc_pkg and the defines header.
`include "arp_cache_with_request_retry_defines.svh"
module arp_cache_with_request_retry #(
  parameter int CACHE_ENTRIES   = arpc_pkg::CacheEntriesDefault,
  parameter int REQUEST_ENTRIES = arpc_pkg::RequestEntriesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  arpc_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output arpc_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [15:0] timeout;
  logic [2:0]  max_tries;
  arpc_pkg::cmd_t      cmd;
  logic                take;
  logic                res_valid;
  arpc_pkg::out_item_t res_item;
  logic                res_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout   <= arpc_pkg::TimeoutReset;
      max_tries <= arpc_pkg::MaxTriesReset;
    end else if (cfg_we) begin
      if (cfg_index == arpc_pkg::CFG_TIMEOUT) timeout <= cfg_data;
      if (cfg_index == arpc_pkg::CFG_MAXTRIES) max_tries <= cfg_data[2:0];
    end
  end

  arpc_front u_front (
    .clk, .rst, .push, .full, .in_item, .cmd, .take
  );

  arpc_engine #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .REQUEST_ENTRIES(REQUEST_ENTRIES)
  ) u_engine (
    .clk, .rst, .cmd, .take, .timeout, .max_tries,
    .res_valid, .res_item, .res_room
  );

  arpc_outq u_outq (
    .clk, .rst, .wr(res_valid), .wr_item(res_item), .room(res_room),
    .empty, .pop, .rd_item(out_item)
  );

  `ARPC_ASSERT(a_take_valid, clk, rst, take |-> cmd.valid, "engine took from an empty queue")
  `ARPC_ASSERT(a_res_room, clk, rst, (res_valid && !res_room) |=> $stable(res_item), "result changed while stalled")
  `ARPC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result queue not empty after reset")

endmodule

FILE: verif/arpc_checker.sv
// Checker for the ARP cache block: predicts every result from accepted items and
// configuration writes, and compares it with what the block delivers.
// Depends on arpc_pkg.
module arpc_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  arpc_pkg::in_item_t  in_item,
  input  logic                empty,
  input  logic                pop,
  input  arpc_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  errors,
  output int                  outstanding,
  output int                  results_seen
);

  localparam int NCache = arpc_pkg::CacheEntriesDefault;
  localparam int NReq   = arpc_pkg::RequestEntriesDefault;

  logic [15:0] timeout_s;
  logic [2:0]  tries_limit;
  logic [31:0] now_s;
  logic        ent_valid [NCache];
  logic [31:0] ent_ip    [NCache];
  logic [47:0] ent_mac   [NCache];
  logic [31:0] ent_added [NCache];
  logic        req_valid [NReq];
  logic [31:0] req_ip    [NReq];
  logic [2:0]  req_tries [NReq];

  arpc_pkg::out_item_t expected_results[$];

  assign outstanding = expected_results.size();

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH t=%0t %s got %0h want %0h", $realtime, field, got, want);
  endtask

  function automatic arpc_pkg::out_item_t make_res(arpc_pkg::res_kind_t k, logic h, logic p,
                                                   logic [47:0] m, logic [31:0] ip,
                                                   logic [2:0] tr, logic l);
    arpc_pkg::out_item_t r;
    r.result_kind = k;
    r.hit = h;
    r.pending_found = p;
    r.out_mac = m;
    r.out_ip = ip;
    r.tries_done = tr;
    r.last = l;
    return r;
  endfunction

  function automatic int find_request(logic [31:0] ip);
    for (int i = 0; i < NReq; i++) if (req_valid[i] && req_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic void predict_arp(arpc_pkg::in_item_t it);
    logic        hit;
    logic        pend;
    logic [47:0] mac;
    logic [2:0]  tr;
    int          r;
    hit = 1'b0;
    pend = 1'b0;
    mac = '0;
    tr = '0;
    case (arpc_pkg::kind_t'(it.kind))
      arpc_pkg::KIND_LOOKUP: begin
        for (int i = 0; i < NCache; i++) begin
          if (ent_valid[i] && ent_ip[i] == it.ip_addr) begin
            hit = 1'b1;
            mac = ent_mac[i];
          end
        end
        expected_results.push_back(make_res(arpc_pkg::RES_LOOKUP, hit, 1'b0, mac, '0, '0,
                                            1'b1));
      end
      arpc_pkg::KIND_INSERT: begin
        r = find_request(it.ip_addr);
        if (r >= 0) begin
          pend = 1'b1;
          tr = req_tries[r];
          req_valid[r] = 1'b0;
        end
        for (int i = 0; i < NCache; i++) begin
          if (!ent_valid[i]) begin
            ent_valid[i] = 1'b1;
            ent_ip[i] = it.ip_addr;
            ent_mac[i] = it.mac_addr;
            ent_added[i] = now_s;
            hit = 1'b1;
            break;
          end
        end
        expected_results.push_back(make_res(arpc_pkg::RES_INSERT, hit, pend, '0, it.ip_addr,
                                            tr, 1'b1));
      end
      arpc_pkg::KIND_QUEUE: begin
        r = find_request(it.ip_addr);
        if (r >= 0) begin
          hit = 1'b1;
          pend = 1'b1;
          tr = req_tries[r];
        end else begin
          for (int i = 0; i < NReq; i++) begin
            if (!req_valid[i]) begin
              req_valid[i] = 1'b1;
              req_ip[i] = it.ip_addr;
              req_tries[i] = '0;
              hit = 1'b1;
              break;
            end
          end
        end
        expected_results.push_back(make_res(arpc_pkg::RES_QUEUE, hit, pend, '0, it.ip_addr,
                                            tr, 1'b1));
      end
      default: begin
        now_s = now_s + 32'd1;
        // Ages wrap with the clock, so the subtraction stays modulo 2^32.
        for (int i = 0; i < NCache; i++)
          if (ent_valid[i] && (now_s - ent_added[i]) > {16'd0, timeout_s}) ent_valid[i] = 1'b0;
        for (int i = 0; i < NReq; i++) begin
          if (req_valid[i]) begin
            if (req_tries[i] >= tries_limit) begin
              expected_results.push_back(make_res(arpc_pkg::RES_GIVEUP, 1'b0, 1'b0, '0,
                                                  req_ip[i], req_tries[i], 1'b0));
              req_valid[i] = 1'b0;
            end else begin
              req_tries[i] = req_tries[i] + 3'd1;
              expected_results.push_back(make_res(arpc_pkg::RES_SEND, 1'b0, 1'b0, '0,
                                                  req_ip[i], req_tries[i], 1'b0));
            end
          end
        end
        expected_results.push_back(make_res(arpc_pkg::RES_DONE, 1'b0, 1'b0, '0, '0, '0,
                                            1'b1));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    arpc_pkg::out_item_t want;
    if (rst) begin
      timeout_s <= arpc_pkg::TimeoutReset;
      tries_limit <= arpc_pkg::MaxTriesReset;
      now_s = '0;
      for (int i = 0; i < NCache; i++) ent_valid[i] = 1'b0;
      for (int i = 0; i < NReq; i++) req_valid[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == arpc_pkg::CFG_TIMEOUT) timeout_s <= cfg_data;
        else tries_limit <= cfg_data[2:0];
      end
      if (push && !full) predict_arp(in_item);
      if (pop && !empty) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report("unexpected result", 64'(out_item), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.result_kind != want.result_kind)
            report("result_kind", 64'(out_item.result_kind), 64'(want.result_kind));
          if (out_item.hit != want.hit) report("hit", 64'(out_item.hit), 64'(want.hit));
          if (out_item.pending_found != want.pending_found)
            report("pending_found", 64'(out_item.pending_found), 64'(want.pending_found));
          if (out_item.out_mac != want.out_mac)
            report("out_mac", 64'(out_item.out_mac), 64'(want.out_mac));
          if (out_item.out_ip != want.out_ip)
            report("out_ip", 64'(out_item.out_ip), 64'(want.out_ip));
          if (out_item.tries_done != want.tries_done)
            report("tries_done", 64'(out_item.tries_done), 64'(want.tries_done));
          if (out_item.last != want.last) report("last", 64'(out_item.last), 64'(want.last));
        end
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
// Top of the ARP cache testbench: clock, reset, item and configuration stimulus,
// and the verdict. Depends on arpc_pkg, arpc_checker and the block itself.
module tb_top;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  arpc_pkg::in_item_t  in_item;
  logic                empty;
  logic                pop;
  arpc_pkg::out_item_t out_item;
  logic                cfg_we;
  logic                cfg_index;
  logic [15:0]         cfg_data;
  int                  errors;
  int                  outstanding;
  int                  results_seen;
  int                  items_sent;
  logic                calm;
  logic [31:0]         ip_pool[12];

  arp_cache_with_request_retry i_dut (
    .clk, .rst, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  arpc_checker i_checker (
    .clk, .rst, .push, .full, .in_item, .empty, .pop, .out_item,
    .cfg_we, .cfg_index, .cfg_data, .errors, .outstanding, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: stalls about one cycle in nine unless the calm stretch is on.
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      pop <= !rst && (calm || $urandom_range(0, 99) >= 11);
    end
  end

  task automatic send_item(arpc_pkg::kind_t k, logic [31:0] ip, logic [47:0] mac);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 11) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= '{kind: k, ip_addr: ip, mac_addr: mac};
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  // Waits for the block to drain before touching its registers.
  task automatic set_config(logic [15:0] tmo, logic [2:0] tries);
    push <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= arpc_pkg::CFG_TIMEOUT;
    cfg_data <= tmo;
    @(posedge clk);
    cfg_index <= arpc_pkg::CFG_MAXTRIES;
    cfg_data <= {13'($urandom), tries};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return ip_pool[$urandom_range(0, 11)];
  endfunction

  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) send_item(arpc_pkg::KIND_LOOKUP, pick_ip(), rand_mac());
    else if (sel < 55) send_item(arpc_pkg::KIND_INSERT, pick_ip(), rand_mac());
    else if (sel < 80) send_item(arpc_pkg::KIND_QUEUE, pick_ip(), rand_mac());
    else send_item(arpc_pkg::KIND_TICK, pick_ip(), rand_mac());
  endtask

  initial begin
    logic [15:0] tmo_list[6];
    logic [2:0]  tries_list[6];
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = arpc_pkg::CFG_TIMEOUT;
    cfg_data = '0;
    calm = 1'b0;
    items_sent = 0;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < 12; i++) ip_pool[i] = $urandom;
    tmo_list = '{16'd15, 16'd0, 16'd1, 16'hFFFF, 16'd2, 16'($urandom_range(1, 65535))};
    tries_list = '{3'd5, 3'd0, 3'd1, 3'd7, 3'd3, 3'($urandom_range(1, 7))};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, duplicates, request retirement and retries at reset settings.
    send_item(arpc_pkg::KIND_LOOKUP, 32'h0, 48'h0);
    send_item(arpc_pkg::KIND_INSERT, 32'h0, 48'h0);
    send_item(arpc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(arpc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(arpc_pkg::KIND_LOOKUP, 32'h0, 48'h0);
    send_item(arpc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
    send_item(arpc_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_item(arpc_pkg::KIND_QUEUE, 32'h0A00_0001, 48'h0);
    send_item(arpc_pkg::KIND_QUEUE, 32'h0A00_0001, 48'h0);
    send_item(arpc_pkg::KIND_QUEUE, 32'hFFFF_FFFF, 48'h0);
    for (int i = 0; i < 6; i++) send_item(arpc_pkg::KIND_TICK, 32'h0, 48'h0);
    send_item(arpc_pkg::KIND_QUEUE, 32'h0A00_0002, 48'h0);
    send_item(arpc_pkg::KIND_TICK, 32'h0, 48'h0);
    send_item(arpc_pkg::KIND_INSERT, 32'h0A00_0002, rand_mac());
    send_item(arpc_pkg::KIND_LOOKUP, 32'h0A00_0002, 48'h0);
    for (int i = 0; i < 12; i++) send_item(arpc_pkg::KIND_TICK, 32'h0, 48'h0);
    send_item(arpc_pkg::KIND_LOOKUP, 32'h0, 48'h0);

    for (int p = 0; p < 6; p++) begin
      set_config(tmo_list[p], tries_list[p]);
      calm = (p == 3);
      // One phase fills both tables to their limits.
      if (p == 3) begin
        for (int i = 0; i < 18; i++) send_item(arpc_pkg::KIND_QUEUE, $urandom, 48'h0);
        for (int i = 0; i < 18; i++) send_item(arpc_pkg::KIND_INSERT, pick_ip(), rand_mac());
      end
      for (int i = 0; i < 27; i++) random_item();
    end
    calm = 1'b0;
    push <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d items over six register settings, checked %0d results.",
             items_sent, results_seen);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
